### src/cai_pkg.sv
// Shared types, constants and helpers for the circular arc interpolator.
// No dependencies; every other file takes what it needs from here.
package cai_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 4096;

    // CORDIC: 30 iterations, 32-bit binary phase
    localparam int CORDIC_ITERS = 30;
    localparam int ITER_W       = 5;
    localparam int XY_W         = 36;
    localparam int Z_W          = 34;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 36'sd652032874;

    localparam logic [31:0] ATAN_PHASE [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // shared multiplier
    localparam int MUL_W = 33;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS_PER_UNIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TOLERANCE     = 1'b1;
    localparam logic [10:0] SPU_RESET = 11'd10;
    localparam logic [15:0] TOL_RESET = 16'd66;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] center_offset_x;
        logic signed [31:0] center_offset_y;
        logic               clockwise;
        logic [15:0]        feed_rate;
    } t_cmd_beat;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        point_feed;
        logic               last_point;
    } t_pt_beat;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return $signed(v[31:0]);
    endfunction

endpackage

### src/cai_if.sv
// Valid/ready channels for command beats and point beats.
// Depends on cai_pkg for the payload types.
interface cai_cmd_if;
    logic                 valid;
    logic                 ready;
    cai_pkg::t_cmd_beat   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cai_pt_if;
    logic                 valid;
    logic                 ready;
    cai_pkg::t_pt_beat    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/circular_arc_interpolator.sv
// Top level of the circular arc interpolator: sequencer, shared units, ports.
// Depends on cai_pkg, cai_if, cai_mul and cai_cordic.
//
// G2/G3 arc interpolator, Q16.16 coordinates, 32-bit binary phase angles.
// A load beat (command 0) sets up an arc and gives no point; it keeps the
// command channel busy through the 32-step bit-serial square root for the
// radius, two 30-iteration CORDIC vectoring runs for the start and end
// angles, and a 33-step restoring divide for the angle step. Each step beat
// (command 1) gives one point, mostly through the 30 CORDIC rotations of the
// shared CORDIC unit, plus the index*step product and the two radius*cos/sin
// products on the one shared 33x33 multiplier. The appended exact end point,
// and the lone end point of an arc with zero segments, skip the CORDIC and
// the multiplier. A step beat with no arc running is swallowed. Points leave
// through an output register, so the next command beat is taken while the
// last point waits for the consumer. Configuration writes are expected only
// while the block is idle.
module circular_arc_interpolator #(
    parameter int MAX_SEGMENTS = cai_pkg::MAX_SEGMENTS,
    parameter int FRAC_BITS    = cai_pkg::FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cai_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cai_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    cai_cmd_if.sink                            i_cmd,
    cai_pt_if.source                           o_pt
);
    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_LOAD = 22'h000002,
        S_DIFF = 22'h000004,
        S_SQX  = 22'h000008,
        S_SQY  = 22'h000010,
        S_SQS  = 22'h000020,
        S_SQRT = 22'h000040,
        S_VEC1 = 22'h000080,
        S_VEC2 = 22'h000100,
        S_VEC3 = 22'h000200,
        S_CNT  = 22'h000400,
        S_CNT2 = 22'h000800,
        S_DIV  = 22'h001000,
        S_DIVE = 22'h002000,
        S_TH   = 22'h004000,
        S_TH2  = 22'h008000,
        S_ROT  = 22'h010000,
        S_PX   = 22'h020000,
        S_PY   = 22'h040000,
        S_PY2  = 22'h080000,
        S_CHK  = 22'h100000,
        S_EMIT = 22'h200000
    } t_state;

    localparam int XW = cai_pkg::XY_W;
    localparam int ZW = cai_pkg::Z_W;
    localparam int MW = cai_pkg::MUL_W;

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_spu, n_spu;
    logic [15:0] r_tol, n_tol;

    // arc state
    logic signed [31:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [31:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [31:0] r_tx, n_tx, r_ty, n_ty;
    logic [15:0]        r_feed, n_feed;
    logic               r_cw, n_cw;
    logic signed [31:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [32:0] r_ex, n_ex, r_ey, n_ey;
    logic [31:0]        r_radius, n_radius;
    logic [31:0]        r_start_angle, n_start_angle;
    logic [32:0]        r_sw_mag, n_sw_mag;
    logic [15:0]        r_total, n_total;
    logic [31:0]        r_step, n_step;
    logic [15:0]        r_idx, n_idx;
    logic               r_active, n_active;
    logic               r_end_pending, n_end_pending;

    // iteration state (root, divide)
    logic [63:0]        r_acc, n_acc;
    logic [63:0]        r_root, n_root;
    logic [5:0]         r_k, n_k;
    logic [15:0]        r_rem, n_rem;
    logic [32:0]        r_dvd, n_dvd;

    // point being formed
    logic               r_flip, n_flip;
    logic signed [31:0] r_px, n_px, r_py, n_py;
    logic               r_last, n_last;

    // output register
    cai_pkg::t_pt_beat  r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // shared units
    logic signed [MW-1:0]   w_mul_a, w_mul_b;
    logic signed [2*MW-1:0] w_mul_p;
    cai_pkg::t_cordic_ctl   w_cor_ctl;
    logic signed [XW-1:0]   w_cor_xi, w_cor_yi, w_cor_xo, w_cor_yo;
    logic signed [ZW-1:0]   w_cor_zi, w_cor_zo;
    logic                   w_cor_done;

    // helpers
    logic signed [XW-1:0]   w_vx, w_vy, w_cos, w_sin;
    logic                   w_vneg;
    logic [63:0]            w_bit, w_trial;
    logic [31:0]            w_theta, w_tq, w_ph, w_d;
    logic                   w_flip;
    logic [2*MW-1:0]        w_cnt;
    logic [16:0]            w_rt;
    logic [32:0]            w_q, w_adx, w_ady;
    logic signed [32:0]     w_ddx, w_ddy;
    logic signed [39:0]     w_sx40, w_sy40, w_prod40;

    cai_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    cai_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cor_ctl),
        .i_x     (w_cor_xi),
        .i_y     (w_cor_yi),
        .i_z     (w_cor_zi),
        .o_done  (w_cor_done),
        .o_x     (w_cor_xo),
        .o_y     (w_cor_yo),
        .o_z     (w_cor_zo)
    );

    // Operand steering for the shared multiplier and CORDIC.
    always_comb begin
        w_cos = r_flip ? -w_cor_xo : w_cor_xo;
        w_sin = r_flip ? -w_cor_yo : w_cor_yo;

        unique case (r_state)
            S_SQX: begin
                w_mul_a = $signed({r_dx[31], r_dx});
                w_mul_b = $signed({r_dx[31], r_dx});
            end
            S_SQY: begin
                w_mul_a = $signed({r_dy[31], r_dy});
                w_mul_b = $signed({r_dy[31], r_dy});
            end
            S_CNT: begin
                w_mul_a = $signed({1'b0, r_radius});
                w_mul_b = $signed({22'd0, r_spu});
            end
            S_TH: begin
                w_mul_a = $signed({17'd0, r_idx});
                w_mul_b = $signed({1'b0, r_step});
            end
            S_PX: begin
                w_mul_a = $signed({1'b0, r_radius});
                w_mul_b = w_cos[MW-1:0];
            end
            S_PY: begin
                w_mul_a = $signed({1'b0, r_radius});
                w_mul_b = w_sin[MW-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase

        // vectoring source: start vector first, end vector second;
        // left half plane is folded over by half a turn
        if (r_state == S_VEC1) begin
            w_vx = $signed({{(XW-32){r_dx[31]}}, r_dx});
            w_vy = $signed({{(XW-32){r_dy[31]}}, r_dy});
        end else begin
            w_vx = $signed({{(XW-33){r_ex[32]}}, r_ex});
            w_vy = $signed({{(XW-33){r_ey[32]}}, r_ey});
        end
        w_vneg = w_vx[XW-1];

        // phase of the next point, folded into the right half plane
        w_theta = r_start_angle + w_mul_p[31:0];
        w_tq    = w_theta + 32'h4000_0000;
        w_flip  = w_tq[31];
        w_ph    = w_flip ? (w_theta - 32'h8000_0000) : w_theta;

        w_cor_ctl.start  = 1'b0;
        w_cor_ctl.rotate = 1'b0;
        if (r_state == S_TH2) begin
            w_cor_ctl.start  = 1'b1;
            w_cor_ctl.rotate = 1'b1;
            w_cor_xi = cai_pkg::CORDIC_GAIN;
            w_cor_yi = '0;
            w_cor_zi = $signed({{(ZW-32){w_ph[31]}}, w_ph});
        end else begin
            w_cor_ctl.start = (r_state == S_VEC1) || ((r_state == S_VEC2) && w_cor_done);
            w_cor_xi = w_vneg ? -w_vx : w_vx;
            w_cor_yi = w_vneg ? -w_vy : w_vy;
            w_cor_zi = w_vneg ? $signed({{(ZW-32){1'b0}}, 32'h8000_0000}) : '0;
        end
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state       = r_state;
        n_spu         = r_spu;
        n_tol         = r_tol;
        n_sx          = r_sx;
        n_sy          = r_sy;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_tx          = r_tx;
        n_ty          = r_ty;
        n_feed        = r_feed;
        n_cw          = r_cw;
        n_dx          = r_dx;
        n_dy          = r_dy;
        n_ex          = r_ex;
        n_ey          = r_ey;
        n_radius      = r_radius;
        n_start_angle = r_start_angle;
        n_sw_mag      = r_sw_mag;
        n_total       = r_total;
        n_step        = r_step;
        n_idx         = r_idx;
        n_active      = r_active;
        n_end_pending = r_end_pending;
        n_acc         = r_acc;
        n_root        = r_root;
        n_k           = r_k;
        n_rem         = r_rem;
        n_dvd         = r_dvd;
        n_flip        = r_flip;
        n_px          = r_px;
        n_py          = r_py;
        n_last        = r_last;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !o_pt.ready;

        w_bit    = 64'd1 << (7'd62 - {r_k, 1'b0});
        w_trial  = r_root + w_bit;
        w_d      = r_cw ? (r_start_angle - w_cor_zo[31:0]) : (w_cor_zo[31:0] - r_start_angle);
        w_cnt    = $unsigned(w_mul_p) >> FRAC_BITS;
        w_rt     = {r_rem, r_dvd[32]};
        w_q      = r_cw ? (33'd0 - r_dvd) : r_dvd;
        w_sx40   = $signed({{24{i_cmd.payload.start_x[15]}}, i_cmd.payload.start_x})
                   <<< FRAC_BITS;
        w_sy40   = $signed({{24{i_cmd.payload.start_y[15]}}, i_cmd.payload.start_y})
                   <<< FRAC_BITS;
        w_prod40 = $signed({{4{w_mul_p[2*MW-1]}}, w_mul_p[2*MW-1:30]});
        w_ddx    = $signed({r_px[31], r_px}) - $signed({r_tx[31], r_tx});
        w_ddy    = $signed({r_py[31], r_py}) - $signed({r_ty[31], r_ty});
        w_adx    = w_ddx[32] ? (33'd0 - w_ddx) : w_ddx;
        w_ady    = w_ddy[32] ? (33'd0 - w_ddy) : w_ddy;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cai_pkg::CFG_SEGMENTS_PER_UNIT: n_spu = i_cfg_data[10:0];
                cai_pkg::CFG_END_TOLERANCE:     n_tol = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.payload.command == cai_pkg::CMD_LOAD) begin
                        n_sx   = cai_pkg::sat32(w_sx40);
                        n_sy   = cai_pkg::sat32(w_sy40);
                        // centre offset parked in the centre registers until S_LOAD adds the start point
                        n_cx   = i_cmd.payload.center_offset_x;
                        n_cy   = i_cmd.payload.center_offset_y;
                        n_tx   = i_cmd.payload.end_x;
                        n_ty   = i_cmd.payload.end_y;
                        n_cw   = i_cmd.payload.clockwise;
                        n_feed = i_cmd.payload.feed_rate;
                        n_state = S_LOAD;
                    end else if (r_active) begin
                        if (r_end_pending || (r_total == '0)) begin
                            // exact end point closes the arc
                            n_px          = r_tx;
                            n_py          = r_ty;
                            n_last        = 1'b1;
                            n_active      = 1'b0;
                            n_end_pending = 1'b0;
                            n_state       = S_EMIT;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_TH;
                        end
                    end
                end
            end
            S_LOAD: begin
                n_cx = cai_pkg::sat32($signed({{8{r_sx[31]}}, r_sx}) +
                                      $signed({{8{r_cx[31]}}, r_cx}));
                n_cy = cai_pkg::sat32($signed({{8{r_sy[31]}}, r_sy}) +
                                      $signed({{8{r_cy[31]}}, r_cy}));
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_dx = cai_pkg::sat32($signed({{8{r_sx[31]}}, r_sx}) -
                                      $signed({{8{r_cx[31]}}, r_cx}));
                n_dy = cai_pkg::sat32($signed({{8{r_sy[31]}}, r_sy}) -
                                      $signed({{8{r_cy[31]}}, r_cy}));
                n_ex = $signed({r_tx[31], r_tx}) - $signed({r_cx[31], r_cx});
                n_ey = $signed({r_ty[31], r_ty}) - $signed({r_cy[31], r_cy});
                n_state = S_SQX;
            end
            S_SQX: n_state = S_SQY;
            S_SQY: begin
                n_acc   = w_mul_p[63:0];
                n_state = S_SQS;
            end
            S_SQS: begin
                n_acc   = r_acc + w_mul_p[63:0];
                n_root  = '0;
                n_k     = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // one result bit per cycle, MSB first
                if (r_acc >= w_trial) begin
                    n_acc  = r_acc - w_trial;
                    n_root = (r_root >> 1) + w_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_k = r_k + 1'b1;
                if (r_k == 6'd31) begin
                    n_radius = n_root[31:0];
                    n_state  = S_VEC1;
                end
            end
            S_VEC1: n_state = S_VEC2;
            S_VEC2: begin
                if (w_cor_done) begin
                    n_start_angle = w_cor_zo[31:0];
                    n_state       = S_VEC3;
                end
            end
            S_VEC3: begin
                if (w_cor_done) begin
                    // equal angles sweep a full turn
                    n_sw_mag = (w_d == '0) ? {1'b1, 32'd0} : {1'b0, w_d};
                    n_state  = S_CNT;
                end
            end
            S_CNT: n_state = S_CNT2;
            S_CNT2: begin
                n_total = (w_cnt > (2*MW)'(MAX_SEGMENTS))
                          ? 16'(MAX_SEGMENTS) : w_cnt[15:0];
                n_rem   = '0;
                n_dvd   = r_sw_mag;
                n_k     = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rt >= {1'b0, r_total}) begin
                    n_rem = 16'(w_rt - {1'b0, r_total});
                    n_dvd = {r_dvd[31:0], 1'b1};
                end else begin
                    n_rem = w_rt[15:0];
                    n_dvd = {r_dvd[31:0], 1'b0};
                end
                n_k = r_k + 1'b1;
                if (r_k == 6'd32) begin
                    n_state = S_DIVE;
                end
            end
            S_DIVE: begin
                n_step        = (r_total == '0) ? 32'd0 : w_q[31:0];
                n_idx         = '0;
                n_end_pending = 1'b0;
                n_active      = 1'b1;
                n_state       = S_IDLE;
            end
            S_TH: n_state = S_TH2;
            S_TH2: begin
                n_flip  = w_flip;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (w_cor_done) begin
                    n_state = S_PX;
                end
            end
            S_PX: n_state = S_PY;
            S_PY: begin
                n_px    = cai_pkg::sat32($signed({{8{r_cx[31]}}, r_cx}) + w_prod40);
                n_state = S_PY2;
            end
            S_PY2: begin
                n_py    = cai_pkg::sat32($signed({{8{r_cy[31]}}, r_cy}) + w_prod40);
                n_state = S_CHK;
            end
            S_CHK: begin
                n_last = 1'b0;
                if (r_idx >= r_total) begin
                    if ((w_adx > {17'd0, r_tol}) || (w_ady > {17'd0, r_tol})) begin
                        n_end_pending = 1'b1;
                    end else begin
                        n_active = 1'b0;
                        n_last   = 1'b1;
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_pt.ready) begin
                    n_out.point_x    = r_px;
                    n_out.point_y    = r_py;
                    n_out.point_feed = r_feed;
                    n_out.last_point = r_last;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_spu         <= cai_pkg::SPU_RESET;
            r_tol         <= cai_pkg::TOL_RESET;
            r_active      <= 1'b0;
            r_end_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_spu         <= n_spu;
            r_tol         <= n_tol;
            r_active      <= n_active;
            r_end_pending <= n_end_pending;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx          <= n_sx;
        r_sy          <= n_sy;
        r_cx          <= n_cx;
        r_cy          <= n_cy;
        r_tx          <= n_tx;
        r_ty          <= n_ty;
        r_feed        <= n_feed;
        r_cw          <= n_cw;
        r_dx          <= n_dx;
        r_dy          <= n_dy;
        r_ex          <= n_ex;
        r_ey          <= n_ey;
        r_radius      <= n_radius;
        r_start_angle <= n_start_angle;
        r_sw_mag      <= n_sw_mag;
        r_total       <= n_total;
        r_step        <= n_step;
        r_idx         <= n_idx;
        r_acc         <= n_acc;
        r_root        <= n_root;
        r_k           <= n_k;
        r_rem         <= n_rem;
        r_dvd         <= n_dvd;
        r_flip        <= n_flip;
        r_px          <= n_px;
        r_py          <= n_py;
        r_last        <= n_last;
        r_out         <= n_out;
    end

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_pt.valid    = r_out_valid;
    assign o_pt.payload  = r_out;
endmodule

### src/cai_mul.sv
// Shared signed multiplier with registered product.
// Depends on cai_pkg for the operand width.
module cai_mul (
    input  logic                              i_clk,
    input  logic signed [cai_pkg::MUL_W-1:0]  i_a,
    input  logic signed [cai_pkg::MUL_W-1:0]  i_b,
    output logic signed [2*cai_pkg::MUL_W-1:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

### src/cai_cordic.sv
// Iterative CORDIC, one micro-rotation a cycle, vectoring or rotation mode.
// Depends on cai_pkg for widths and the arctangent table.
module cai_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cai_pkg::t_cordic_ctl               i_ctl,
    input  logic signed [cai_pkg::XY_W-1:0]    i_x,
    input  logic signed [cai_pkg::XY_W-1:0]    i_y,
    input  logic signed [cai_pkg::Z_W-1:0]     i_z,
    output logic                               o_done,
    output logic signed [cai_pkg::XY_W-1:0]    o_x,
    output logic signed [cai_pkg::XY_W-1:0]    o_y,
    output logic signed [cai_pkg::Z_W-1:0]     o_z
);
    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic                             r_rot, n_rot;
    logic [cai_pkg::ITER_W-1:0]       r_i, n_i;
    logic signed [cai_pkg::XY_W-1:0]  r_x, n_x, r_y, n_y, w_xs, w_ys;
    logic signed [cai_pkg::Z_W-1:0]   r_z, n_z, w_a;
    logic                             w_pos;

    always_comb begin
        w_xs  = r_x >>> r_i;
        w_ys  = r_y >>> r_i;
        w_a   = $signed({{(cai_pkg::Z_W-32){1'b0}}, cai_pkg::ATAN_PHASE[r_i]});
        // rotation: drive z to zero; vectoring: drive y to zero (y = 0 counts as negative)
        w_pos = r_rot ? !r_z[cai_pkg::Z_W-1]
                      : (r_y[cai_pkg::XY_W-1] || (r_y == '0));
        n_busy = r_busy;
        n_done = 1'b0;
        n_rot  = r_rot;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_rot  = i_ctl.rotate;
            n_i    = '0;
            n_x    = i_x;
            n_y    = i_y;
            n_z    = i_z;
        end else if (r_busy) begin
            if (w_pos) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_a;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_a;
            end
            n_i = r_i + 1'b1;
            if (r_i == cai_pkg::ITER_W'(cai_pkg::CORDIC_ITERS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
        r_i   <= n_i;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

### src/cai_chk.sv
// Port-level checks for the circular arc interpolator, bound to the top level.
// Depends on cai_pkg and the top level's channel interfaces.
module cai_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_command,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input cai_pkg::t_pt_beat i_out_payload
);
    // nothing leaves straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("point beat valid right after reset");

    // an arc load always holds the command channel for its set-up
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_command == cai_pkg::CMD_LOAD)) |=> !i_in_ready)
        else $error("command taken during arc set-up");

    // a fresh point only appears after the sequencer has been busy
    a_point_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("point beat without preceding work");

    // stalled point beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled point beat changed");
endmodule

bind circular_arc_interpolator cai_chk u_cai_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_in_command  (i_cmd.payload.command),
    .i_out_valid   (o_pt.valid),
    .i_out_ready   (o_pt.ready),
    .i_out_payload (o_pt.payload)
);
